// ===== sv/feg_pkg.sv =====
`default_nettype none

package feg_pkg;

	// defaults and fixed widths
	localparam int unsigned LEVEL_BITS_DEF = 16;
	localparam int unsigned TIME_BITS      = 18;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	localparam logic [15:0] FADE_IN_RST = 16'd2000;
	localparam logic [15:0] HOLD_RST    = 16'd1000;

	// request codes
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_ACT    = 2'd1;
	localparam logic [1:0] REQ_DEACT  = 2'd2;

	// register indexes
	localparam logic REG_FADE_IN = 1'b0;
	localparam logic REG_HOLD    = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FADEIN,
		PH_ANIMATE,
		PH_FADEOUT
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] elapsed_ms;
		logic [15:0] strength;
		logic        fade_flag;
		logic        animate_flag;
	} req_t;

	typedef struct packed {
		logic [15:0] level;
		logic        active;
	} rsp_t;

	typedef struct packed {
		logic        index;
		logic [15:0] value;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/feg_chan_if.sv =====
`default_nettype none

interface feg_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/fade_envelope_generator.sv =====
// activate, deactivate, idle or finishing ticks give their item in the cycle after accept
// a tick inside a running ramp waits in calc for the bit-serial multiply (18 steps) and divide
//   (LEVEL_BITS steps) in feg_muldiv, then in emit until the output register is free
// throughput: one item at a time; the next item is taken as soon as the result is out
// reset: asynchronous, active low; phase idle, ramp cleared, fade_in_ms 2000, hold_ms 1000
`default_nettype none

module fade_envelope_generator #(
	parameter int unsigned LEVEL_BITS = feg_pkg::LEVEL_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	feg_chan_if.sink   req,
	feg_chan_if.source rsp,
	feg_chan_if.sink   cfg
);
	localparam int unsigned LB = LEVEL_BITS;
	localparam int unsigned TB = feg_pkg::TIME_BITS;

	// configuration registers
	logic [15:0] fade_in_q;
	logic [15:0] hold_q;

	// envelope state
	feg_pkg::state_t state_q, state_n;
	feg_pkg::phase_t phase_q, phase_n;
	logic [LB-1:0]   src_q, src_n;
	logic [LB-1:0]   tgt_q, tgt_n;
	logic [LB-1:0]   cur_q, cur_n;
	logic [TB-1:0]   dur_q, dur_n;
	logic [TB-1:0]   el_q, el_n;
	logic            fm_q, fm_n;
	logic            am_q, am_n;

	// output register, parts the result side from the request side
	logic            rsp_valid_q;
	feg_pkg::rsp_t   rsp_q;
	logic            rsp_load;

	logic            req_acc;
	logic            out_free;
	logic            div_start;
	logic            div_done;
	logic [LB-1:0]   div_q;
	logic            up;
	logic [LB-1:0]   span;
	logic [TB:0]     sum_e;
	logic [TB-1:0]   new_e;
	logic [TB-1:0]   dbl_e;
	logic [LB-1:0]   str;

	assign req_acc  = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// ramp direction and size, rounded toward the source
	assign up   = tgt_q >= src_q;
	assign span = up ? (tgt_q - src_q) : (src_q - tgt_q);

	// elapsed time saturates; fade-out runs over twice the elapsed time
	assign sum_e = {1'b0, el_q} + (TB + 1)'(req.data.elapsed_ms);
	assign new_e = sum_e[TB] ? feg_pkg::TIME_MAX : sum_e[TB-1:0];
	assign dbl_e = el_q[TB-1] ? feg_pkg::TIME_MAX : {el_q[TB-2:0], 1'b0};
	assign str   = LB'(req.data.strength);

	feg_muldiv #(
		.LB (LB),
		.TB (TB)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (span),
		.b      (new_e),
		.d      (dur_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= feg_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		logic finished;
		finished  = 1'b0;
		state_n   = state_q;
		phase_n   = phase_q;
		src_n     = src_q;
		tgt_n     = tgt_q;
		cur_n     = cur_q;
		dur_n     = dur_q;
		el_n      = el_q;
		fm_n      = fm_q;
		am_n      = am_q;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		req.ready = 1'b0;

		unique case (state_q)
			feg_pkg::ST_IDLE: begin
				req.ready = out_free;
				if (req_acc) begin
					rsp_load = 1'b1;
					unique case (req.data.req_type)
						feg_pkg::REQ_ACT: begin
							// activate restarts the envelope from any phase
							am_n = req.data.animate_flag;
							fm_n = req.data.fade_flag;
							el_n = '0;
							if (req.data.fade_flag) begin
								src_n   = '0;
								tgt_n   = str;
								cur_n   = '0;
								dur_n   = TB'(fade_in_q);
								phase_n = feg_pkg::PH_FADEIN;
							end else begin
								src_n   = str;
								tgt_n   = str;
								cur_n   = str;
								dur_n   = TB'(hold_q);
								phase_n = feg_pkg::PH_ANIMATE;
							end
						end
						feg_pkg::REQ_DEACT: begin
							if (phase_q != feg_pkg::PH_IDLE) begin
								if (fm_q) begin
									// fade to zero from wherever the level stands
									src_n   = cur_q;
									tgt_n   = '0;
									dur_n   = dbl_e;
									el_n    = '0;
									phase_n = feg_pkg::PH_FADEOUT;
								end else begin
									phase_n = feg_pkg::PH_IDLE;
								end
							end
						end
						feg_pkg::REQ_TICK: begin
							if (phase_q != feg_pkg::PH_IDLE) begin
								if (el_q > dur_q) begin
									// ramp already over, level untouched
									finished = 1'b1;
								end else begin
									el_n = new_e;
									if (new_e >= dur_q) begin
										// also covers a zero-length ramp
										cur_n    = tgt_q;
										finished = 1'b1;
									end else begin
										// mid-ramp: level needs span * e / d
										div_start = 1'b1;
										rsp_load  = 1'b0;
										state_n   = feg_pkg::ST_CALC;
									end
								end
							end
						end
						default: begin
							// unused request code, nothing changes
						end
					endcase

					if (finished) begin
						unique case (phase_q)
							feg_pkg::PH_FADEIN: begin
								// fade-in end always heads for half the level
								src_n   = cur_n;
								tgt_n   = cur_n >> 1;
								el_n    = '0;
								phase_n = feg_pkg::PH_ANIMATE;
							end
							feg_pkg::PH_FADEOUT: begin
								phase_n = feg_pkg::PH_IDLE;
							end
							feg_pkg::PH_ANIMATE: begin
								if (am_q) begin
									// ping-pong back toward the source
									tgt_n = src_q;
									src_n = cur_n;
									el_n  = '0;
								end
							end
							feg_pkg::PH_IDLE: begin
							end
						endcase
					end
				end
			end
			feg_pkg::ST_CALC: begin
				if (div_done) begin
					cur_n   = up ? (src_q + div_q) : (src_q - div_q);
					state_n = feg_pkg::ST_EMIT;
				end
			end
			feg_pkg::ST_EMIT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_n  = feg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = feg_pkg::ST_IDLE;
			end
		endcase
	end

	// ramp state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= feg_pkg::PH_IDLE;
			src_q     <= '0;
			tgt_q     <= '0;
			cur_q     <= '0;
			dur_q     <= '0;
			el_q      <= '0;
			fm_q      <= 1'b0;
			am_q      <= 1'b0;
			fade_in_q <= feg_pkg::FADE_IN_RST;
			hold_q    <= feg_pkg::HOLD_RST;
		end else begin
			phase_q <= phase_n;
			src_q   <= src_n;
			tgt_q   <= tgt_n;
			cur_q   <= cur_n;
			dur_q   <= dur_n;
			el_q    <= el_n;
			fm_q    <= fm_n;
			am_q    <= am_n;
			if (cfg.valid) begin
				if (cfg.data.index == feg_pkg::REG_FADE_IN) begin
					fade_in_q <= cfg.data.value;
				end else begin
					hold_q <= cfg.data.value;
				end
			end
		end
	end

	// result item, level reads zero while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.active <= (phase_n != feg_pkg::PH_IDLE);
			rsp_q.level  <= (phase_n == feg_pkg::PH_IDLE) ? 16'd0 : 16'(cur_n);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// the divider only answers while a tick waits for it
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == feg_pkg::ST_CALC)
		else $error("divider done outside calc");

	a_start_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && div_start) |=> state_q == feg_pkg::ST_CALC)
		else $error("mid-ramp tick did not enter calc");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.active) |-> rsp.data.level == 16'd0)
		else $error("idle item with non-zero level");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == feg_pkg::ST_CALC) |=> !$rose(rsp.valid))
		else $error("result raised while level still in calc");

endmodule

`default_nettype wire

// ===== sv/feg_muldiv.sv =====
`default_nettype none

// serial floor(a * b / d), a bit per cycle; needs a * b < d * 2^LB
module feg_muldiv #(
	parameter int unsigned LB = feg_pkg::LEVEL_BITS_DEF,
	parameter int unsigned TB = feg_pkg::TIME_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [LB-1:0] a,
	input  wire logic [TB-1:0] b,
	input  wire logic [TB-1:0] d,
	output logic               done,
	output logic      [LB-1:0] q
);
	localparam int unsigned PW = LB + TB;
	localparam int unsigned CW = $clog2(((TB > LB) ? TB : LB) + 1);

	logic          busy_q;
	logic          div_ph_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [PW-1:0] p_q;
	logic [LB-1:0] a_q;
	logic [TB-1:0] d_q;

	logic [LB:0]   mul_sum;
	logic [TB:0]   trial;
	logic [TB:0]   diff;
	logic          ge;

	// shift-add on the upper part, multiplier bits leave at the bottom
	assign mul_sum = {1'b0, p_q[PW-1:TB]} + (p_q[0] ? {1'b0, a_q} : '0);
	// restoring step: remainder in the upper part, quotient shifts in below
	assign trial   = {p_q[PW-1:LB], p_q[LB-1]};
	assign diff    = trial - {1'b0, d_q};
	assign ge      = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			div_ph_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= busy_q && div_ph_q && (cnt_q == '0);
			if (start) begin
				busy_q   <= 1'b1;
				div_ph_q <= 1'b0;
				cnt_q    <= CW'(TB - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					if (div_ph_q) begin
						busy_q <= 1'b0;
					end else begin
						div_ph_q <= 1'b1;
						cnt_q    <= CW'(LB - 1);
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{LB{1'b0}}, b};
			a_q <= a;
			d_q <= d;
		end else if (busy_q) begin
			if (!div_ph_q) begin
				p_q <= {mul_sum, p_q[TB-1:1]};
			end else begin
				p_q <= {(ge ? diff[TB-1:0] : trial[TB-1:0]), p_q[LB-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign q    = p_q[LB-1:0];

endmodule

`default_nettype wire
